>>> hw/rtl/hsv_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies; used by every module of the converter.
`default_nettype none

package hsv_pkg;

    localparam int UNIT       = 256;
    localparam int SECTOR_DEG = 60;
    localparam int FULL_TURN  = 360;

    localparam int UNIT_W  = 9;
    localparam int HUE_W   = 9;
    localparam int REM_W   = 6;
    localparam int LEVEL_W = 14;
    localparam int NUM_W   = 23;
    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 8;

    // floor(x / 15) == (x * RECIP_15) >> RECIP_SHIFT for any 12-bit x
    localparam int RECIP_15    = 4370;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;

    localparam logic [INDEX_W-1:0] REG_SATURATION = 8'd0;
    localparam logic [INDEX_W-1:0] REG_BRIGHTNESS = 8'd1;

    localparam logic [UNIT_W-1:0] SAT_RESET = 9'd256;
    localparam logic [UNIT_W-1:0] BRI_RESET = 9'd26;

    typedef logic [2:0]         sector_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    localparam sector_t SEC_RED_YEL  = 3'd0;
    localparam sector_t SEC_YEL_GRN  = 3'd1;
    localparam sector_t SEC_GRN_CYAN = 3'd2;
    localparam sector_t SEC_CYAN_BLU = 3'd3;
    localparam sector_t SEC_BLU_MAG  = 3'd4;
    localparam sector_t SEC_MAG_RED  = 3'd5;
    localparam sector_t SEC_NONE     = 3'd6;

    typedef struct packed {
        logic    valid;
        sector_t sector;
    } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/hsv_front.sv
// Front stages: hue split into sector and remainder, then the four level numerators.
// Depends on hsv_pkg.
`default_nettype none

module hsv_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [hsv_pkg::HUE_W-1:0]    hue_degrees,
    input  wire logic [hsv_pkg::UNIT_W-1:0]   saturation,
    input  wire logic [hsv_pkg::UNIT_W-1:0]   brightness,
    output hsv_pkg::ctl_t                     ctl,
    output logic [hsv_pkg::UNIT_W-1:0]        bri,
    output hsv_pkg::level_t                   lvl_lo,
    output hsv_pkg::level_t                   lvl_fall,
    output hsv_pkg::level_t                   lvl_rise,
    output hsv_pkg::level_t                   lvl_top
);

    localparam logic [hsv_pkg::HUE_W-1:0]   DEG60  = 9'(hsv_pkg::SECTOR_DEG);
    localparam logic [hsv_pkg::HUE_W-1:0]   TURN   = 9'(hsv_pkg::FULL_TURN);
    localparam logic [hsv_pkg::UNIT_W-1:0]  UNITV  = 9'(hsv_pkg::UNIT);
    localparam logic [hsv_pkg::LEVEL_W-1:0] FULLX  = 14'(hsv_pkg::UNIT * hsv_pkg::SECTOR_DEG);
    localparam logic [hsv_pkg::REM_W-1:0]   DEG60R = 6'(hsv_pkg::SECTOR_DEG);

    hsv_pkg::ctl_t                    s1_ctl_reg, s1_ctl_next;
    logic [hsv_pkg::REM_W-1:0]        s1_rem_reg, s1_rem_next;
    logic [hsv_pkg::UNIT_W-1:0]       s1_sat_reg, s1_sat_next;
    logic [hsv_pkg::UNIT_W-1:0]       s1_bri_reg, s1_bri_next;

    hsv_pkg::ctl_t                    s2_ctl_reg;
    logic [hsv_pkg::UNIT_W-1:0]       s2_bri_reg;
    hsv_pkg::level_t                  s2_lo_reg, s2_lo_next;
    hsv_pkg::level_t                  s2_fall_reg, s2_fall_next;
    hsv_pkg::level_t                  s2_rise_reg, s2_rise_next;

    logic [hsv_pkg::HUE_W-1:0]        hue;
    logic [hsv_pkg::HUE_W-1:0]        base;
    logic [hsv_pkg::HUE_W-1:0]        rem_wide;
    logic [hsv_pkg::LEVEL_W+1:0]      s_rem;
    logic [hsv_pkg::LEVEL_W+1:0]      s_inv;
    logic [hsv_pkg::LEVEL_W+1:0]      lo_wide;

    // Stage 1: clamp registers, fold full turn, split hue
    always_comb
    begin
        s1_sat_next = (saturation > UNITV) ? UNITV : saturation;
        s1_bri_next = (brightness > UNITV) ? UNITV : brightness;
        hue = (hue_degrees == TURN) ? '0 : hue_degrees;
        priority if (hue < DEG60)
        begin
            s1_ctl_next.sector = hsv_pkg::SEC_RED_YEL;
            base = '0;
        end
        else if (hue < 9'(2 * hsv_pkg::SECTOR_DEG))
        begin
            s1_ctl_next.sector = hsv_pkg::SEC_YEL_GRN;
            base = DEG60;
        end
        else if (hue < 9'(3 * hsv_pkg::SECTOR_DEG))
        begin
            s1_ctl_next.sector = hsv_pkg::SEC_GRN_CYAN;
            base = 9'(2 * hsv_pkg::SECTOR_DEG);
        end
        else if (hue < 9'(4 * hsv_pkg::SECTOR_DEG))
        begin
            s1_ctl_next.sector = hsv_pkg::SEC_CYAN_BLU;
            base = 9'(3 * hsv_pkg::SECTOR_DEG);
        end
        else if (hue < 9'(5 * hsv_pkg::SECTOR_DEG))
        begin
            s1_ctl_next.sector = hsv_pkg::SEC_BLU_MAG;
            base = 9'(4 * hsv_pkg::SECTOR_DEG);
        end
        else if (hue < TURN)
        begin
            s1_ctl_next.sector = hsv_pkg::SEC_MAG_RED;
            base = 9'(5 * hsv_pkg::SECTOR_DEG);
        end
        else
        begin
            s1_ctl_next.sector = hsv_pkg::SEC_NONE;
            base = hue;
        end
        // gray: every level equals the top, any sector will do
        if (s1_sat_next == '0)
        begin
            s1_ctl_next.sector = hsv_pkg::SEC_RED_YEL;
        end
        rem_wide = hue - base;
        s1_rem_next = rem_wide[hsv_pkg::REM_W-1:0];
        s1_ctl_next.valid = start;
    end

    // Stage 2: level numerators over 256*60
    always_comb
    begin
        s_rem = 16'(s1_sat_reg) * 16'(s1_rem_reg);
        s_inv = 16'(s1_sat_reg) * 16'(DEG60R - s1_rem_reg);
        lo_wide = 16'(UNITV - s1_sat_reg) * 16'(DEG60);
        s2_lo_next   = lo_wide[hsv_pkg::LEVEL_W-1:0];
        s2_fall_next = FULLX - s_rem[hsv_pkg::LEVEL_W-1:0];
        s2_rise_next = FULLX - s_inv[hsv_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rem_reg  <= s1_rem_next;
        s1_sat_reg  <= s1_sat_next;
        s1_bri_reg  <= s1_bri_next;
        s2_bri_reg  <= s1_bri_reg;
        s2_lo_reg   <= s2_lo_next;
        s2_fall_reg <= s2_fall_next;
        s2_rise_reg <= s2_rise_next;
    end

    assign ctl      = s2_ctl_reg;
    assign bri      = s2_bri_reg;
    assign lvl_lo   = s2_lo_reg;
    assign lvl_fall = s2_fall_reg;
    assign lvl_rise = s2_rise_reg;
    assign lvl_top  = FULLX;

endmodule

`default_nettype wire

>>> hw/rtl/hsv_scale.sv
// Channel scaler: floor(255 * v * x / (256*256*60)) over three register stages.
// Depends on hsv_pkg.
`default_nettype none

module hsv_scale (
    input  wire logic                        clk,
    input  wire logic [hsv_pkg::UNIT_W-1:0]  bri,
    input  wire hsv_pkg::level_t             level,
    output hsv_pkg::chan_t                   chan
);

    localparam int PROD_W = hsv_pkg::NUM_W + 8;
    localparam int Q_W    = hsv_pkg::LEVEL_W;
    localparam int X_W    = Q_W - 2;
    localparam int M_W    = X_W + hsv_pkg::RECIP_W;

    logic [hsv_pkg::NUM_W-1:0] num_reg, num_next;
    logic [Q_W-1:0]            q_reg, q_next;
    hsv_pkg::chan_t            chan_reg, chan_next;
    logic [PROD_W-1:0]         p255;
    logic [M_W-1:0]            m;

    always_comb
    begin
        num_next  = hsv_pkg::NUM_W'(bri) * hsv_pkg::NUM_W'(level);
        // times 255, then drop the 2^16 part of the divisor
        p255      = (PROD_W'(num_reg) << 8) - PROD_W'(num_reg);
        q_next    = p255[hsv_pkg::RECIP_SHIFT +: Q_W];
        // divide by 60: drop 4, then divide by 15 through the reciprocal
        m         = M_W'(q_reg[Q_W-1:2]) * M_W'(hsv_pkg::RECIP_15);
        chan_next = m[hsv_pkg::RECIP_SHIFT +: hsv_pkg::CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        q_reg    <= q_next;
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: configuration registers, pipeline, output mux.
// Depends on hsv_pkg, hsv_front and hsv_scale.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | start, busy, hue_degrees                | start & !busy
//  result   | done, red, green, blue, packed_color    | done, one cycle
//  config   | cfg_we, cfg_index, cfg_data             | cfg_we
//
// One item per clock; busy stays low. Six register stages: two front stages,
// three scaling stages (multiply, times 255, reciprocal multiply) and the output
// register. The first loads at the edge that takes the item; each result is then on
// the ports with done, both from output registers. Reset clears all valid bits and
// loads saturation 256 and brightness 26. The receiver cannot stall.
`default_nettype none

module hsv_to_rgb_converter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [hsv_pkg::HUE_W-1:0]     hue_degrees,
    input  wire logic                          cfg_we,
    input  wire logic [hsv_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [hsv_pkg::UNIT_W-1:0]    cfg_data,
    output logic                               done,
    output logic [hsv_pkg::CHAN_W-1:0]         red,
    output logic [hsv_pkg::CHAN_W-1:0]         green,
    output logic [hsv_pkg::CHAN_W-1:0]         blue,
    output logic [3*hsv_pkg::CHAN_W-1:0]       packed_color
);

    localparam int SCALE_STAGES = 3;

    logic [hsv_pkg::UNIT_W-1:0] sat_reg;
    logic [hsv_pkg::UNIT_W-1:0] bri_reg;

    hsv_pkg::ctl_t              front_ctl;
    logic [hsv_pkg::UNIT_W-1:0] front_bri;
    hsv_pkg::level_t            lvl_lo, lvl_fall, lvl_rise, lvl_top;
    hsv_pkg::chan_t             ch_lo, ch_fall, ch_rise, ch_top;

    hsv_pkg::ctl_t              ctl_pipe_reg [SCALE_STAGES];
    logic                       done_reg;
    hsv_pkg::chan_t             red_reg, red_next;
    hsv_pkg::chan_t             green_reg, green_next;
    hsv_pkg::chan_t             blue_reg, blue_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= hsv_pkg::SAT_RESET;
            bri_reg <= hsv_pkg::BRI_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == hsv_pkg::REG_SATURATION)
            begin
                sat_reg <= cfg_data;
            end
            if (cfg_index == hsv_pkg::REG_BRIGHTNESS)
            begin
                bri_reg <= cfg_data;
            end
        end
    end

    hsv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .hue_degrees (hue_degrees),
        .saturation  (sat_reg),
        .brightness  (bri_reg),
        .ctl         (front_ctl),
        .bri         (front_bri),
        .lvl_lo      (lvl_lo),
        .lvl_fall    (lvl_fall),
        .lvl_rise    (lvl_rise),
        .lvl_top     (lvl_top)
    );

    hsv_scale u_scale_lo   (.clk(clk), .bri(front_bri), .level(lvl_lo),   .chan(ch_lo));
    hsv_scale u_scale_fall (.clk(clk), .bri(front_bri), .level(lvl_fall), .chan(ch_fall));
    hsv_scale u_scale_rise (.clk(clk), .bri(front_bri), .level(lvl_rise), .chan(ch_rise));
    hsv_scale u_scale_top  (.clk(clk), .bri(front_bri), .level(lvl_top),  .chan(ch_top));

    // hold sector and valid alongside the scaling stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SCALE_STAGES; i++)
            begin
                ctl_pipe_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_pipe_reg[0] <= front_ctl;
            for (int i = 1; i < SCALE_STAGES; i++)
            begin
                ctl_pipe_reg[i] <= ctl_pipe_reg[i-1];
            end
            done_reg <= ctl_pipe_reg[SCALE_STAGES-1].valid;
        end
    end

    always_comb
    begin
        unique case (ctl_pipe_reg[SCALE_STAGES-1].sector)
            hsv_pkg::SEC_RED_YEL:
            begin
                red_next = ch_top;  green_next = ch_rise; blue_next = ch_lo;
            end
            hsv_pkg::SEC_YEL_GRN:
            begin
                red_next = ch_fall; green_next = ch_top;  blue_next = ch_lo;
            end
            hsv_pkg::SEC_GRN_CYAN:
            begin
                red_next = ch_lo;   green_next = ch_top;  blue_next = ch_rise;
            end
            hsv_pkg::SEC_CYAN_BLU:
            begin
                red_next = ch_lo;   green_next = ch_fall; blue_next = ch_top;
            end
            hsv_pkg::SEC_BLU_MAG:
            begin
                red_next = ch_rise; green_next = ch_lo;   blue_next = ch_top;
            end
            hsv_pkg::SEC_MAG_RED:
            begin
                red_next = ch_top;  green_next = ch_lo;   blue_next = ch_fall;
            end
            default:
            begin
                red_next = '0;      green_next = '0;      blue_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign packed_color = {red_reg, green_reg, blue_reg};

endmodule

`default_nettype wire

>>> test/hsv_to_rgb_converter_tb.sv
// Self-checking testbench for hsv_to_rgb_converter: hue items in, RGB results checked
// against an internal predictor that tracks the saturation and brightness registers.
// Depends on hsv_pkg and the hsv_to_rgb_converter RTL.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [hsv_pkg::HUE_W-1:0] hue;
        hsv_pkg::chan_t            red;
        hsv_pkg::chan_t            green;
        hsv_pkg::chan_t            blue;
    } rgb_expect_t;

    logic                          clk;
    logic                          rst_n       = 1'b0;
    logic                          start       = 1'b0;
    logic [hsv_pkg::HUE_W-1:0]     hue_degrees = '0;
    logic                          cfg_we      = 1'b0;
    logic [hsv_pkg::INDEX_W-1:0]   cfg_index   = '0;
    logic [hsv_pkg::UNIT_W-1:0]    cfg_data    = '0;
    logic                          busy;
    logic                          done;
    hsv_pkg::chan_t                red;
    hsv_pkg::chan_t                green;
    hsv_pkg::chan_t                blue;
    logic [3*hsv_pkg::CHAN_W-1:0]  packed_color;

    logic [hsv_pkg::HUE_W-1:0]     pending_hue[$];
    rgb_expect_t                   expected_rgb[$];
    logic [hsv_pkg::UNIT_W-1:0]    sat_reg = hsv_pkg::SAT_RESET;
    logic [hsv_pkg::UNIT_W-1:0]    bri_reg = hsv_pkg::BRI_RESET;
    int unsigned                   issued_cnt   = 0;
    int unsigned                   taken_cnt    = 0;
    int unsigned                   mismatch_cnt = 0;
    int unsigned                   send_gap_max = 0;
    int unsigned                   gap_left     = 0;
    int unsigned                   cycle_cnt    = 0;

    hsv_to_rgb_converter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .hue_degrees  (hue_degrees),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .packed_color (packed_color)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint unsigned chan_from_level(longint unsigned num);
        return (255 * num) / (hsv_pkg::UNIT * hsv_pkg::UNIT * hsv_pkg::SECTOR_DEG);
    endfunction

    function automatic rgb_expect_t predict_rgb(logic [hsv_pkg::HUE_W-1:0] hue_in,
                                                logic [hsv_pkg::UNIT_W-1:0] sat_raw,
                                                logic [hsv_pkg::UNIT_W-1:0] bri_raw);
        longint unsigned  s, v, rem, lo, fall, rise, top;
        int unsigned      h;
        hsv_pkg::sector_t sec;
        hsv_pkg::chan_t   c_lo, c_fall, c_rise, c_top;
        rgb_expect_t      e;
        s = (sat_raw > hsv_pkg::UNIT) ? hsv_pkg::UNIT : sat_raw;
        v = (bri_raw > hsv_pkg::UNIT) ? hsv_pkg::UNIT : bri_raw;
        top = chan_from_level(v * hsv_pkg::UNIT * hsv_pkg::SECTOR_DEG);
        c_top = hsv_pkg::chan_t'(top);
        e.hue = hue_in;
        if (s == 0)
        begin
            e.red   = c_top;
            e.green = c_top;
            e.blue  = c_top;
        end
        else
        begin
            h    = (hue_in == hsv_pkg::FULL_TURN) ? 0 : hue_in;
            sec  = (h / hsv_pkg::SECTOR_DEG > 5) ? hsv_pkg::SEC_NONE
                                                 : hsv_pkg::sector_t'(h / hsv_pkg::SECTOR_DEG);
            rem  = h % hsv_pkg::SECTOR_DEG;
            lo   = chan_from_level(v * (hsv_pkg::UNIT - s) * hsv_pkg::SECTOR_DEG);
            fall = chan_from_level(v * (hsv_pkg::UNIT * hsv_pkg::SECTOR_DEG - s * rem));
            rise = chan_from_level(v * (hsv_pkg::UNIT * hsv_pkg::SECTOR_DEG -
                                        s * (hsv_pkg::SECTOR_DEG - rem)));
            c_lo   = hsv_pkg::chan_t'(lo);
            c_fall = hsv_pkg::chan_t'(fall);
            c_rise = hsv_pkg::chan_t'(rise);
            case (sec)
                hsv_pkg::SEC_RED_YEL:  {e.red, e.green, e.blue} = {c_top,  c_rise, c_lo};
                hsv_pkg::SEC_YEL_GRN:  {e.red, e.green, e.blue} = {c_fall, c_top,  c_lo};
                hsv_pkg::SEC_GRN_CYAN: {e.red, e.green, e.blue} = {c_lo,   c_top,  c_rise};
                hsv_pkg::SEC_CYAN_BLU: {e.red, e.green, e.blue} = {c_lo,   c_fall, c_top};
                hsv_pkg::SEC_BLU_MAG:  {e.red, e.green, e.blue} = {c_rise, c_lo,   c_top};
                hsv_pkg::SEC_MAG_RED:  {e.red, e.green, e.blue} = {c_top,  c_lo,   c_fall};
                default:               {e.red, e.green, e.blue} = '0;
            endcase
        end
        return e;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && taken_cnt == issued_cnt)
        begin
            if (start)
                gap_left = $urandom_range(0, send_gap_max);
            if (gap_left == 0 && pending_hue.size() != 0)
            begin
                hue_degrees <= pending_hue.pop_front();
                issued_cnt++;
                start <= 1'b1;
            end
            else
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        rgb_expect_t exp_rgb;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_rgb.push_back(predict_rgb(hue_degrees, sat_reg, bri_reg));
                taken_cnt++;
            end
            if (done)
            begin
                if (expected_rgb.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("unexpected result: r %0d g %0d b %0d word %06h",
                                 red, green, blue, packed_color);
                end
                else
                begin
                    exp_rgb = expected_rgb.pop_front();
                    if (red !== exp_rgb.red || green !== exp_rgb.green ||
                        blue !== exp_rgb.blue ||
                        packed_color !== {exp_rgb.red, exp_rgb.green, exp_rgb.blue})
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display({"mismatch hue %0d: expected r %0d g %0d b %0d word %06h,",
                                      " got r %0d g %0d b %0d word %06h"},
                                     exp_rgb.hue, exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                                     {exp_rgb.red, exp_rgb.green, exp_rgb.blue},
                                     red, green, blue, packed_color);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("hsv_to_rgb_converter_tb: errors");
            $finish;
        end
    end

    task automatic write_cfg(input logic [hsv_pkg::INDEX_W-1:0] idx,
                             input logic [hsv_pkg::UNIT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == hsv_pkg::REG_SATURATION)
            sat_reg = val;
        else if (idx == hsv_pkg::REG_BRIGHTNESS)
            bri_reg = val;
    endtask

    task automatic set_levels(input logic [hsv_pkg::UNIT_W-1:0] sat,
                              input logic [hsv_pkg::UNIT_W-1:0] bri);
        write_cfg(hsv_pkg::REG_SATURATION, sat);
        write_cfg(hsv_pkg::REG_BRIGHTNESS, bri);
        write_cfg(hsv_pkg::INDEX_W'($urandom_range(2, 255)),
                  hsv_pkg::UNIT_W'($urandom_range(0, 511)));
    endtask

    task automatic drain_results();
        while (pending_hue.size() != 0 || taken_cnt != issued_cnt || start ||
               expected_rgb.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [hsv_pkg::HUE_W-1:0]  corner_hues[14];
        logic [hsv_pkg::UNIT_W-1:0] level_pick[5];
        logic [hsv_pkg::UNIT_W-1:0] sat_pick, bri_pick;
        int unsigned                phase, n;

        corner_hues = '{9'd0, 9'd1, 9'd30, 9'd59, 9'd60, 9'd119, 9'd120, 9'd180,
                        9'd240, 9'd300, 9'd359, 9'd360, 9'd361, 9'd511};
        level_pick  = '{9'd0, 9'd1, 9'd255, 9'd256, 9'd511};

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset levels first
        foreach (corner_hues[i])
            pending_hue.push_back(corner_hues[i]);
        drain_results();

        // writes to unused indexes must leave the levels alone
        write_cfg(8'd2, 9'd0);
        write_cfg(8'd255, 9'd511);
        pending_hue.push_back(9'd45);
        pending_hue.push_back(9'd200);
        drain_results();

        set_levels(9'd0, 9'd256);
        pending_hue.push_back(9'd0);
        pending_hue.push_back(9'd200);
        pending_hue.push_back(9'd360);
        pending_hue.push_back(9'd511);
        drain_results();

        set_levels(9'd300, 9'd511);
        pending_hue.push_back(9'd45);
        pending_hue.push_back(9'd400);
        drain_results();

        for (phase = 0; phase < 10; phase++)
        begin
            if (phase < 5)
            begin
                sat_pick = level_pick[phase];
                bri_pick = level_pick[4 - phase];
            end
            else
            begin
                sat_pick = ($urandom_range(0, 2) == 0) ? level_pick[$urandom_range(0, 4)]
                                                       : hsv_pkg::UNIT_W'($urandom_range(0, 511));
                bri_pick = ($urandom_range(0, 2) == 0) ? level_pick[$urandom_range(0, 4)]
                                                       : hsv_pkg::UNIT_W'($urandom_range(0, 511));
            end
            set_levels(sat_pick, bri_pick);
            send_gap_max = (phase % 3 == 0) ? 0 : 4;
            for (n = 0; n < 80; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pending_hue.push_back(hsv_pkg::HUE_W'($urandom_range(361, 511)));
                else
                    pending_hue.push_back(hsv_pkg::HUE_W'($urandom_range(0, 360)));
            end
            drain_results();
        end

        repeat (12) @(posedge clk);
        if (mismatch_cnt == 0 && expected_rgb.size() == 0)
            $display("hsv_to_rgb_converter_tb: clean");
        else
            $display("hsv_to_rgb_converter_tb: errors");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/hsv_pkg.sv
hw/rtl/hsv_front.sv
hw/rtl/hsv_scale.sv
hw/rtl/hsv_to_rgb_converter.sv
test/hsv_to_rgb_converter_tb.sv
